[rtl/double_crc16_crc12_appender_top_assert.svh]
// Assertion macros used by the framer's checker.
`ifndef DOUBLE_CRC16_CRC12_APPENDER_TOP_ASSERT_SVH
`define DOUBLE_CRC16_CRC12_APPENDER_TOP_ASSERT_SVH

// Implication checked outside reset.
`define DCRC_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked outside reset.
`define DCRC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds through reset.
`define DCRC_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/dcrc_pkg.sv]
// ----------------------------------------------------------------------------
// dcrc_pkg
// Types, constants and CRC byte-update functions for the double CRC framer.
// ----------------------------------------------------------------------------
package dcrc_pkg;

  localparam logic [15:0] CRC16_POLY = 16'h8005;
  localparam logic [11:0] CRC12_POLY = 12'h80F;

  localparam logic [1:0] PART_MSG   = 2'd0;
  localparam logic [1:0] PART_CRC16 = 2'd1;
  localparam logic [1:0] PART_CRC12 = 2'd2;

  typedef struct packed {
    logic [7:0] message_byte;
    logic       last_byte;
  } dcrc_in_t;

  typedef struct packed {
    logic [3:0] hex_nibble;
    logic [1:0] part;
    logic       last_nibble;
  } dcrc_out_t;

  // Queue word from front to back: byte plus CRC state after that byte.
  typedef struct packed {
    logic [7:0]  message_byte;
    logic        last_byte;
    logic [15:0] crc16;
    logic [11:0] crc12;
  } dcrc_entry_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ data[i];
      c  = {c[14:0], 1'b0} ^ (fb ? CRC16_POLY : 16'h0000);
    end
    return c;
  endfunction

  function automatic logic [11:0] crc12_byte(input logic [11:0] crc, input logic [7:0] data);
    logic [11:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[11] ^ data[i];
      c  = {c[10:0], 1'b0} ^ (fb ? CRC12_POLY : 12'h000);
    end
    return c;
  endfunction

endpackage

[rtl/dcrc_fifo.sv]
// ----------------------------------------------------------------------------
// dcrc_fifo
// Small show-ahead queue between the front and back of the framer.
// ----------------------------------------------------------------------------
module dcrc_fifo #(
  parameter int W     = 37,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         not_empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/dcrc_front.sv]
// ----------------------------------------------------------------------------
// dcrc_front
// Runs both CRCs a byte per cycle unless q_full and queues each byte's result.
// ----------------------------------------------------------------------------
module dcrc_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  dcrc_pkg::dcrc_in_t    in_word,
  input  logic                  q_full,
  output logic                  q_push,
  output dcrc_pkg::dcrc_entry_t q_entry
);
  import dcrc_pkg::*;

  logic [15:0] crc16_r, crc16_nxt;
  logic [11:0] crc12_r, crc12_nxt;
  logic [15:0] crc16_upd;
  logic [11:0] crc12_upd;

  assign in_ready  = !q_full;
  assign q_push    = in_valid && !q_full;
  assign crc16_upd = crc16_byte(crc16_r, in_word.message_byte);
  assign crc12_upd = crc12_byte(crc12_r, in_word.message_byte);

  assign q_entry.message_byte = in_word.message_byte;
  assign q_entry.last_byte    = in_word.last_byte;
  assign q_entry.crc16        = crc16_upd;
  assign q_entry.crc12        = crc12_upd;

  always_comb begin
    crc16_nxt = crc16_r;
    crc12_nxt = crc12_r;
    if (q_push) begin
      // registers restart at zero once a message closes
      crc16_nxt = in_word.last_byte ? 16'h0000 : crc16_upd;
      crc12_nxt = in_word.last_byte ? 12'h000 : crc12_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc16_r <= '0;
      crc12_r <= '0;
    end else begin
      crc16_r <= crc16_nxt;
      crc12_r <= crc12_nxt;
    end
  end

endmodule

[rtl/dcrc_back.sv]
// ----------------------------------------------------------------------------
// dcrc_back
// Walks one queued byte out as nibbles, appending both CRCs on a last byte.
// ----------------------------------------------------------------------------
module dcrc_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  dcrc_pkg::dcrc_entry_t q_entry,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output dcrc_pkg::dcrc_out_t   out_word
);
  import dcrc_pkg::*;

  localparam logic [3:0] IDX_LO_NIB   = 4'd1;
  localparam logic [3:0] IDX_C16_HI   = 4'd2;
  localparam logic [3:0] IDX_C16_LO   = 4'd3;
  localparam logic [3:0] IDX_LAST_NIB = 4'd8;

  logic        busy_r, busy_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        last_r, last_nxt;
  logic [15:0] c16_r, c16_nxt;
  logic [11:0] c12_r, c12_nxt;
  logic        out_valid_r, out_valid_nxt;
  dcrc_out_t   out_word_r, out_word_nxt;

  logic        advance;
  logic        final_step;
  logic        load;
  dcrc_out_t   nib;

  assign advance    = busy_r && (!out_valid_r || out_ready);
  assign final_step = (idx_r == IDX_LO_NIB && !last_r) || (idx_r == IDX_LAST_NIB);
  assign load       = q_valid && (!busy_r || (advance && final_step));
  assign q_pop      = load;
  assign out_valid  = out_valid_r;
  assign out_word   = out_word_r;

  always_comb begin
    nib.hex_nibble  = 4'h0;
    nib.part        = PART_MSG;
    nib.last_nibble = 1'b0;
    case (idx_r)
      4'd0: nib.hex_nibble = byte_r[7:4];
      4'd1: nib.hex_nibble = byte_r[3:0];
      4'd2: begin
        nib.hex_nibble = c16_r[15:12];
        nib.part       = PART_CRC16;
      end
      4'd3: begin
        nib.hex_nibble = c16_r[11:8];
        nib.part       = PART_CRC16;
      end
      4'd4: begin
        nib.hex_nibble = c16_r[7:4];
        nib.part       = PART_CRC16;
      end
      4'd5: begin
        nib.hex_nibble = c16_r[3:0];
        nib.part       = PART_CRC16;
      end
      4'd6: begin
        nib.hex_nibble = c12_r[11:8];
        nib.part       = PART_CRC12;
      end
      4'd7: begin
        nib.hex_nibble = c12_r[7:4];
        nib.part       = PART_CRC12;
      end
      4'd8: begin
        nib.hex_nibble  = c12_r[3:0];
        nib.part        = PART_CRC12;
        nib.last_nibble = 1'b1;
      end
      default: nib.hex_nibble = 4'h0;
    endcase
  end

  always_comb begin
    busy_nxt      = busy_r;
    idx_nxt       = idx_r;
    byte_nxt      = byte_r;
    last_nxt      = last_r;
    c16_nxt       = c16_r;
    c12_nxt       = c12_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;

    if (advance) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = nib;
      idx_nxt       = idx_r + 1'b1;
      // CRC-16 is folded into the CRC-12 a byte at a time while it goes out
      if (idx_r == IDX_C16_HI) begin
        c12_nxt = crc12_byte(c12_r, c16_r[15:8]);
      end else if (idx_r == IDX_C16_LO) begin
        c12_nxt = crc12_byte(c12_r, c16_r[7:0]);
      end
      if (final_step) begin
        busy_nxt = 1'b0;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (load) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
      byte_nxt = q_entry.message_byte;
      last_nxt = q_entry.last_byte;
      c16_nxt  = q_entry.crc16;
      c12_nxt  = q_entry.crc12;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    last_r     <= last_nxt;
    c16_r      <= c16_nxt;
    c12_r      <= c12_nxt;
    out_word_r <= out_word_nxt;
  end

endmodule

[rtl/double_crc16_crc12_appender_top.sv]
// ----------------------------------------------------------------------------
// double_crc16_crc12_appender_top
// Frames a byte stream as hex nibbles with a CRC-16 and a CRC-12 appended.
// ----------------------------------------------------------------------------
// Input words carry one message byte and a last flag; both CRCs take the
// byte MSB first. Each output word is one nibble tagged as message, CRC-16
// or CRC-12, with last_nibble set on the closing CRC-12 nibble.
// An ordinary byte gives two nibbles, a last byte nine (two message, four
// CRC-16, three CRC-12). Nibbles leave at one per cycle while out_ready
// is high and the queue is not empty. When the block is empty, the first
// nibble of a taken byte goes through the queue, the back end's byte
// state and the output word register before out_valid rises.
// The front computes both CRCs a whole byte per cycle while in_ready is
// high and queues each byte with its CRC state, so input is taken while
// the output stalls, until the queue (QUEUE_DEPTH words) fills.
// in_ready then drops. A stalled output word holds its value until taken.
// Reset clears both CRCs, empties the queue and drops out_valid.
// ----------------------------------------------------------------------------
module double_crc16_crc12_appender_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dcrc_pkg::dcrc_in_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output dcrc_pkg::dcrc_out_t out_word
);
  import dcrc_pkg::*;

  logic        q_full;
  logic        q_push;
  logic        q_pop;
  logic        q_valid;
  dcrc_entry_t q_wr_entry;
  dcrc_entry_t q_rd_entry;

  dcrc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_wr_entry)
  );

  dcrc_fifo #(
    .W     ($bits(dcrc_entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wr_entry),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rd_entry),
    .not_empty (q_valid)
  );

  dcrc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_entry   (q_rd_entry),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

[rtl/dcrc_checker.sv]
// ----------------------------------------------------------------------------
// dcrc_checker
// Port-level checks on the framer, bound to the top level.
// ----------------------------------------------------------------------------
`include "double_crc16_crc12_appender_top_assert.svh"

module dcrc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input dcrc_pkg::dcrc_in_t  in_word,
  input logic                out_valid,
  input logic                out_ready,
  input dcrc_pkg::dcrc_out_t out_word
);
  import dcrc_pkg::*;

  `DCRC_ASSERT_NXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_word), "input word changed while waiting")
  `DCRC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word), "output word changed while stalled")
  `DCRC_ASSERT(a_part_code, out_valid, out_word.part == PART_MSG || out_word.part == PART_CRC16 || out_word.part == PART_CRC12, "bad part code")
  `DCRC_ASSERT(a_last_is_crc12, out_valid && out_word.last_nibble, out_word.part == PART_CRC12, "last_nibble on a non CRC-12 nibble")
  `DCRC_ASSERT_RST(a_reset_idle, !rst_n, !out_valid, "out_valid high after reset")

endmodule

bind double_crc16_crc12_appender_top dcrc_checker u_dcrc_checker (.*);

[dv/double_crc16_crc12_appender_top_tb.sv]
// ----------------------------------------------------------------------------
// double_crc16_crc12_appender_top_tb
// Self-checking bench for the CRC-16 / CRC-12 hex nibble framer.
// ----------------------------------------------------------------------------
// A directed table covers zero and all-ones bytes, one-byte and multi-byte
// messages and the clearing of both CRCs between messages; random messages
// follow. Nibbles are checked against a bit-serial predictor of both CRCs,
// or against hand-worked values on typed rows, with random gaps on the byte
// side and random stalls on the nibble side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module double_crc16_crc12_appender_top_tb;
  import dcrc_pkg::*;

  typedef struct packed {
    logic [7:0]  msg;
    logic        last;
    logic        typed;
    logic [3:0]  hi;
    logic [3:0]  lo;
    logic [15:0] c16;
    logic [11:0] c12;
  } byte_row_t;

  // typed rows carry hand-worked nibbles; CRC columns matter on typed last bytes
  localparam int NUM_ROWS = 14;
  localparam byte_row_t BYTE_ROWS [NUM_ROWS] = '{
    '{8'h00, 1'b1, 1'b1, 4'h0, 4'h0, 16'h0000, 12'h000},  // all-zero message
    '{8'hFF, 1'b0, 1'b1, 4'hF, 4'hF, 16'h0000, 12'h000},
    '{8'h00, 1'b0, 1'b1, 4'h0, 4'h0, 16'h0000, 12'h000},
    '{8'h80, 1'b0, 1'b0, 4'h0, 4'h0, 16'h0000, 12'h000},
    '{8'h01, 1'b1, 1'b0, 4'h0, 4'h0, 16'h0000, 12'h000},
    '{8'hA5, 1'b1, 1'b0, 4'h0, 4'h0, 16'h0000, 12'h000},  // one-byte message
    '{8'h00, 1'b1, 1'b1, 4'h0, 4'h0, 16'h0000, 12'h000},  // CRCs cleared
    '{8'hF0, 1'b0, 1'b1, 4'hF, 4'h0, 16'h0000, 12'h000},
    '{8'h0F, 1'b0, 1'b1, 4'h0, 4'hF, 16'h0000, 12'h000},
    '{8'h5A, 1'b0, 1'b0, 4'h0, 4'h0, 16'h0000, 12'h000},
    '{8'hFF, 1'b1, 1'b0, 4'h0, 4'h0, 16'h0000, 12'h000},
    '{8'hFF, 1'b1, 1'b0, 4'h0, 4'h0, 16'h0000, 12'h000},
    '{8'h7E, 1'b0, 1'b0, 4'h0, 4'h0, 16'h0000, 12'h000},
    '{8'h00, 1'b1, 1'b0, 4'h0, 4'h0, 16'h0000, 12'h000}
  };

  localparam int RANDOM_BYTES = 120;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  dcrc_in_t  in_word;
  logic      out_valid;
  logic      out_ready;
  dcrc_out_t out_word;

  // predictor state
  logic [15:0] crc16_acc;
  logic [11:0] crc12_acc;
  dcrc_out_t   nibbles_due[$];

  int  mismatches;
  int  bytes_sent;
  int  messages_sent;
  int  nibbles_checked;
  bit  tx_fast;
  bit  rx_fast;
  int  rx_wait;
  int  rx_draw;

  double_crc16_crc12_appender_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #200000;
    $display("** double_crc16_crc12_appender_top: FAILED **");
    $finish;
  end

  function automatic logic [15:0] crc16_bit(input logic [15:0] c, input logic d);
    return {c[14:0], 1'b0} ^ ((c[15] ^ d) ? CRC16_POLY : 16'h0000);
  endfunction

  function automatic logic [11:0] crc12_bit(input logic [11:0] c, input logic d);
    return {c[10:0], 1'b0} ^ ((c[11] ^ d) ? CRC12_POLY : 12'h000);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch @%0t: %s got %0h want %0h", $time, what, got, want);
    mismatches++;
  endtask

  // Queue the nibbles of one byte, plus the CRC trailer on a last byte.
  task automatic queue_frame(input logic [3:0] hi, input logic [3:0] lo, input logic last,
                             input logic [15:0] c16, input logic [11:0] c12);
    nibbles_due.push_back('{hi, PART_MSG, 1'b0});
    nibbles_due.push_back('{lo, PART_MSG, 1'b0});
    if (last) begin
      for (int i = 3; i >= 0; i--) nibbles_due.push_back('{c16[4*i +: 4], PART_CRC16, 1'b0});
      for (int i = 2; i >= 0; i--)
        nibbles_due.push_back('{c12[4*i +: 4], PART_CRC12, (i == 0)});
    end
  endtask

  // Advance both CRCs by one byte; on a last byte fold the CRC-16 into the
  // CRC-12, hand back the trailer values and clear.
  task automatic predict_byte(input logic [7:0] b, input logic last,
                              output logic [15:0] c16, output logic [11:0] c12);
    for (int i = 7; i >= 0; i--) begin
      crc16_acc = crc16_bit(crc16_acc, b[i]);
      crc12_acc = crc12_bit(crc12_acc, b[i]);
    end
    c16 = crc16_acc;
    if (last) begin
      for (int i = 15; i >= 0; i--) crc12_acc = crc12_bit(crc12_acc, c16[i]);
    end
    c12 = crc12_acc;
    if (last) begin
      crc16_acc = '0;
      crc12_acc = '0;
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = tx_fast ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= '{b, last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    if (last) messages_sent++;
  endtask

  task automatic send_predicted(input logic [7:0] b, input logic last);
    logic [15:0] c16;
    logic [11:0] c12;
    send_byte(b, last);
    predict_byte(b, last, c16, c12);
    queue_frame(b[7:4], b[3:0], last, c16, c12);
  endtask

  task automatic wait_drained;
    while (nibbles_due.size() != 0) @(posedge clk);
  endtask

  // nibble side: random stall after each accepted word
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait   <= 0;
    end else if (out_valid && out_ready) begin
      rx_draw = rx_fast ? 0 : $urandom_range(0, 11);
      rx_wait   <= rx_draw;
      out_ready <= (rx_draw == 0);
    end else if (rx_wait > 0) begin
      rx_wait   <= rx_wait - 1;
      out_ready <= (rx_wait == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    dcrc_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (nibbles_due.size() == 0) begin
        report_mismatch("word with none due", out_word, 0);
      end else begin
        want = nibbles_due.pop_front();
        nibbles_checked++;
        if (out_word.hex_nibble !== want.hex_nibble)
          report_mismatch("hex_nibble", out_word.hex_nibble, want.hex_nibble);
        if (out_word.part !== want.part)
          report_mismatch("part", out_word.part, want.part);
        if (out_word.last_nibble !== want.last_nibble)
          report_mismatch("last_nibble", out_word.last_nibble, want.last_nibble);
      end
    end
  end

  initial begin
    logic [15:0] c16;
    logic [11:0] c12;
    logic [7:0]  b;
    int          len;
    int          rand_bytes;
    bit          paused;
    int          settle;

    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_word         = '0;
    crc16_acc       = '0;
    crc12_acc       = '0;
    mismatches      = 0;
    bytes_sent      = 0;
    messages_sent   = 0;
    nibbles_checked = 0;
    tx_fast         = 1'b0;
    rx_fast         = 1'b0;
    rand_bytes      = 0;
    paused          = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < NUM_ROWS; r++) begin
      if (BYTE_ROWS[r].typed) begin
        send_byte(BYTE_ROWS[r].msg, BYTE_ROWS[r].last);
        predict_byte(BYTE_ROWS[r].msg, BYTE_ROWS[r].last, c16, c12);
        queue_frame(BYTE_ROWS[r].hi, BYTE_ROWS[r].lo, BYTE_ROWS[r].last,
                    BYTE_ROWS[r].c16, BYTE_ROWS[r].c12);
      end else begin
        send_predicted(BYTE_ROWS[r].msg, BYTE_ROWS[r].last);
      end
    end

    // random messages; some run with no gaps or stalls at all
    while (rand_bytes < RANDOM_BYTES) begin
      tx_fast = ($urandom_range(0, 3) == 0);
      rx_fast = ($urandom_range(0, 3) == 0);
      len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 8);
      for (int k = 0; k < len; k++) begin
        case ($urandom_range(0, 7))
          0:       b = 8'h00;
          1:       b = 8'hFF;
          default: b = $urandom_range(0, 255);
        endcase
        send_predicted(b, k == len - 1);
        rand_bytes++;
      end
      if (!paused && rand_bytes >= RANDOM_BYTES / 2) begin
        // hold the byte side off until the framer has emptied
        in_valid <= 1'b0;
        wait_drained();
        paused = 1'b1;
      end
    end
    in_valid <= 1'b0;

    wait_drained();
    settle = 0;
    while (settle < 20) begin
      @(posedge clk);
      settle++;
    end
    if (nibbles_due.size() != 0)
      report_mismatch("nibbles never emitted", 0, nibbles_due.size());

    $display("covered %0d bytes in %0d messages, %0d nibbles checked",
             bytes_sent, messages_sent, nibbles_checked);
    $display("with random gaps and stalls on both sides, %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("** double_crc16_crc12_appender_top: PASSED **");
    end else begin
      $display("** double_crc16_crc12_appender_top: FAILED **");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/dcrc_pkg.sv
rtl/dcrc_fifo.sv
rtl/dcrc_front.sv
rtl/dcrc_back.sv
rtl/double_crc16_crc12_appender_top.sv
rtl/dcrc_checker.sv
dv/double_crc16_crc12_appender_top_tb.sv
